// ----- sv/rgb_neighbour_mean_blur_defines.svh -----
// ----------------------------------------------------------------------------
// rgb neighbour mean blur assertion macros
// Concurrent assertion helpers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef RGB_NEIGHBOUR_MEAN_BLUR_DEFINES_SVH
`define RGB_NEIGHBOUR_MEAN_BLUR_DEFINES_SVH
`ifndef SYNTHESIS
`define RNMB_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define RNMB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define RNMB_ASSERT(lbl, clk, rst_n, prop, msg)
`define RNMB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- sv/rnmb_pkg.sv -----
// ----------------------------------------------------------------------------
// rnmb_pkg
// Shared types and constants of the rgb neighbour mean blur.
// ----------------------------------------------------------------------------
package rnmb_pkg;

  localparam int FW_W       = 12;
  localparam int FH_W       = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [FW_W-1:0] FW_RESET = 12'd2048;
  localparam logic [FH_W-1:0] FH_RESET = 16'd1;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    pixel_t [8:0] win;
    logic         interior;
    logic         last;
  } job_t;

endpackage

// ----- sv/rnmb_if.sv -----
// ----------------------------------------------------------------------------
// rnmb channel interfaces
// Pixel input, result output and register write channels.
// ----------------------------------------------------------------------------
interface rnmb_pix_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;

  modport source (output valid, operation, red_in, green_in, blue_in, input ready);
  modport sink (input valid, operation, red_in, green_in, blue_in, output ready);
endinterface

interface rnmb_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic       frame_end;

  modport source (output valid, red_out, green_out, blue_out, frame_end, input ready);
  modport sink (input valid, red_out, green_out, blue_out, frame_end, output ready);
endinterface

interface rnmb_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [rnmb_pkg::CFG_IDX_W-1:0]   index;
  logic [rnmb_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- sv/rgb_neighbour_mean_blur.sv -----
// ----------------------------------------------------------------------------
// rgb_neighbour_mean_blur
// 3x3 neighbour mean blur over a raster order rgb pixel stream.
// ----------------------------------------------------------------------------
// usage
// - in_i takes one pixel beat per clock while the job queue has room; operation
//   marks a drain beat, which enters the pipeline as a zero pixel
// - out_o gives one blurred pixel per beat, frame_end on the last pixel
// - cfg_i writes frame_width (index 0) and frame_height (index 1); the user must
//   write only while the block is idle, which it does not enforce; always ready
// - a result belongs to the beat one line plus one pixel earlier; send
//   width+1 drain beats after the last pixel of a frame
// - a result passes the staging registers, the job queue and the output register
// - throughput: one beat per cycle while the queue has room, set by the line
//   buffer read at accept and its write in the cycle after
// - on a stall of out_o, jobs collect in a 4 entry queue and in_i stays
//   ready until it would overflow
// - reset clears the counters, the window and the queue; sizes return to
//   width 2048 and height 1; the line buffers need no clearing
// ----------------------------------------------------------------------------
`include "rgb_neighbour_mean_blur_defines.svh"

module rgb_neighbour_mean_blur #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rnmb_pix_if.sink    in_i,
  rnmb_res_if.source  out_o,
  rnmb_cfg_if.sink    cfg_i
);

  logic [rnmb_pkg::FW_W-1:0]     frame_width_q;
  logic [rnmb_pkg::FH_W-1:0]     frame_height_q;
  logic                          push;
  logic                          pop;
  logic                          job_valid;
  rnmb_pkg::job_t                job_in, job_head;
  logic [rnmb_pkg::QCNT_W-1:0]   q_count;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= rnmb_pkg::FW_RESET;
      frame_height_q <= rnmb_pkg::FH_RESET;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        rnmb_pkg::CFG_FRAME_WIDTH: begin
          frame_width_q <= cfg_i.data[rnmb_pkg::FW_W-1:0];
        end
        rnmb_pkg::CFG_FRAME_HEIGHT: begin
          frame_height_q <= cfg_i.data[rnmb_pkg::FH_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  rnmb_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_i           (in_i),
    .frame_width_i  (frame_width_q),
    .frame_height_i (frame_height_q),
    .q_count_i      (q_count),
    .push_o         (push),
    .job_o          (job_in)
  );

  rnmb_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .pop_i   (pop),
    .job_o   (job_head),
    .valid_o (job_valid),
    .count_o (q_count)
  );

  rnmb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (job_head),
    .job_valid_i (job_valid),
    .pop_o       (pop),
    .out_o       (out_o)
  );

  `RNMB_ASSERT(a_ready_credit, clk_i, rst_ni, !(in_i.ready && (q_count == rnmb_pkg::QCNT_W'(rnmb_pkg::QDEPTH))), "input ready with full queue")

endmodule

// ----- sv/rnmb_ram.sv -----
// ----------------------------------------------------------------------------
// rnmb_ram
// Generic simple dual port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module rnmb_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/rnmb_front.sv -----
// ----------------------------------------------------------------------------
// rnmb_front
// Accepts pixels, tracks frame position, runs the line buffers and window.
// ----------------------------------------------------------------------------
`include "rgb_neighbour_mean_blur_defines.svh"

module rnmb_front #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  rnmb_pix_if.sink                      in_i,
  input  logic [rnmb_pkg::FW_W-1:0]     frame_width_i,
  input  logic [rnmb_pkg::FH_W-1:0]     frame_height_i,
  input  logic [rnmb_pkg::QCNT_W-1:0]   q_count_i,
  output logic                          push_o,
  output rnmb_pkg::job_t                job_o
);

  localparam int FW_MAX = (1 << rnmb_pkg::FW_W) - 1;
  localparam int WMAX   = (MAX_WIDTH < FW_MAX) ? MAX_WIDTH : FW_MAX;
  localparam int CW     = $clog2(WMAX);
  localparam int WW     = $clog2(WMAX + 1);
  localparam int AW     = $clog2(MAX_WIDTH);
  localparam int RW     = rnmb_pkg::FH_W + 1;
  localparam logic [rnmb_pkg::FW_W-1:0] WMAX_FW = rnmb_pkg::FW_W'(WMAX);

  logic                        acc;
  logic [WW-1:0]               w_eff;
  logic [rnmb_pkg::FH_W-1:0]   h_eff;
  rnmb_pkg::pixel_t            pix_a;

  logic [CW-1:0]               in_col_q, in_col_d;
  logic [1:0]                  in_row_q, in_row_d;
  logic [CW-1:0]               out_col_q, out_col_d;
  logic [rnmb_pkg::FH_W-1:0]   out_row_q, out_row_d;

  logic [WW-1:0]               in_col_p1, out_col_p1;
  logic                        in_wrap, out_col_wrap, out_row_wrap;
  logic                        full, interior, last;
  logic [AW-1:0]               raddr;

  logic                        sb_valid_q;
  logic [AW-1:0]               sb_addr_q;
  rnmb_pkg::pixel_t            sb_pix_q;
  logic                        sb_full_q, sb_int_q, sb_last_q;
  logic                        sb_fwd_q;
  rnmb_pkg::pixel_t            sb_fwd_up_q, sb_fwd_mid_q;

  logic [23:0]                 up_rdata, mid_rdata;
  rnmb_pkg::pixel_t            up_eff, mid_eff;
  rnmb_pkg::pixel_t [8:0]      win_q, win_d;

  assign in_i.ready = (q_count_i + rnmb_pkg::QCNT_W'(sb_valid_q))
                      < rnmb_pkg::QCNT_W'(rnmb_pkg::QDEPTH);
  assign acc = in_i.valid & in_i.ready;

  always_comb begin
    if (frame_width_i == '0) begin
      w_eff = WW'(1);
    end else if (frame_width_i > WMAX_FW) begin
      w_eff = WW'(WMAX);
    end else begin
      w_eff = WW'(frame_width_i);
    end
    h_eff = (frame_height_i == '0) ? rnmb_pkg::FH_W'(1) : frame_height_i;
  end

  always_comb begin
    pix_a = '0;
    if (in_i.operation == rnmb_pkg::OP_PIXEL) begin
      pix_a.red   = in_i.red_in;
      pix_a.green = in_i.green_in;
      pix_a.blue  = in_i.blue_in;
    end
  end

  // frame position and classification at accept time
  always_comb begin
    in_col_p1    = WW'(in_col_q) + WW'(1);
    out_col_p1   = WW'(out_col_q) + WW'(1);
    in_wrap      = in_col_p1 >= w_eff;
    out_col_wrap = out_col_p1 >= w_eff;
    out_row_wrap = (RW'(out_row_q) + RW'(1)) >= RW'(h_eff);
    full         = (in_row_q == 2'd2) || ((in_row_q == 2'd1) && (in_col_q != '0));
    last         = out_row_wrap && out_col_wrap;
    interior     = (out_row_q != '0) && !out_row_wrap &&
                   (out_col_q != '0) && !out_col_wrap;
    raddr        = AW'(in_col_q);

    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    if (acc) begin
      if (full && last) begin
        in_col_d  = '0;
        in_row_d  = '0;
        out_col_d = '0;
        out_row_d = '0;
      end else begin
        if (in_wrap) begin
          in_col_d = '0;
          if (in_row_q != 2'd2) begin
            in_row_d = in_row_q + 2'd1;
          end
        end else begin
          in_col_d = CW'(in_col_p1);
        end
        if (full) begin
          if (out_col_wrap) begin
            out_col_d = '0;
            out_row_d = out_row_q + rnmb_pkg::FH_W'(1);
          end else begin
            out_col_d = CW'(out_col_p1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q   <= '0;
      in_row_q   <= '0;
      out_col_q  <= '0;
      out_row_q  <= '0;
      sb_valid_q <= 1'b0;
      win_q      <= '0;
    end else begin
      in_col_q   <= in_col_d;
      in_row_q   <= in_row_d;
      out_col_q  <= out_col_d;
      out_row_q  <= out_row_d;
      sb_valid_q <= acc;
      win_q      <= win_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      sb_addr_q    <= raddr;
      sb_pix_q     <= pix_a;
      sb_full_q    <= full;
      sb_int_q     <= interior;
      sb_last_q    <= last;
      sb_fwd_q     <= sb_valid_q && (sb_addr_q == raddr);
      sb_fwd_up_q  <= mid_eff;
      sb_fwd_mid_q <= sb_pix_q;
    end
  end

  rnmb_ram #(
    .WIDTH (24),
    .DEPTH (MAX_WIDTH)
  ) u_upper_line (
    .clk_i   (clk_i),
    .we_i    (sb_valid_q),
    .waddr_i (sb_addr_q),
    .wdata_i (mid_eff),
    .re_i    (acc),
    .raddr_i (raddr),
    .rdata_o (up_rdata)
  );

  rnmb_ram #(
    .WIDTH (24),
    .DEPTH (MAX_WIDTH)
  ) u_middle_line (
    .clk_i   (clk_i),
    .we_i    (sb_valid_q),
    .waddr_i (sb_addr_q),
    .wdata_i (sb_pix_q),
    .re_i    (acc),
    .raddr_i (raddr),
    .rdata_o (mid_rdata)
  );

  // line buffer write of the previous beat bypasses the read
  always_comb begin
    up_eff  = sb_fwd_q ? sb_fwd_up_q  : rnmb_pkg::pixel_t'(up_rdata);
    mid_eff = sb_fwd_q ? sb_fwd_mid_q : rnmb_pkg::pixel_t'(mid_rdata);
    win_d   = win_q;
    if (sb_valid_q) begin
      for (int r = 0; r < 3; r++) begin
        win_d[r*3]     = win_q[r*3+1];
        win_d[r*3+1]   = win_q[r*3+2];
      end
      win_d[2] = up_eff;
      win_d[5] = mid_eff;
      win_d[8] = sb_pix_q;
    end
  end

  assign push_o         = sb_valid_q & sb_full_q;
  assign job_o.win      = win_d;
  assign job_o.interior = sb_int_q;
  assign job_o.last     = sb_last_q;

  `RNMB_ASSERT_NEXT(a_frame_clear, clk_i, rst_ni, acc && full && last, (in_col_q == '0) && (in_row_q == '0) && (out_col_q == '0) && (out_row_q == '0), "counters not cleared at frame end")

endmodule

// ----- sv/rnmb_queue.sv -----
// ----------------------------------------------------------------------------
// rnmb_queue
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
`include "rgb_neighbour_mean_blur_defines.svh"

module rnmb_queue (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  rnmb_pkg::job_t                job_i,
  input  logic                          pop_i,
  output rnmb_pkg::job_t                job_o,
  output logic                          valid_o,
  output logic [rnmb_pkg::QCNT_W-1:0]   count_o
);

  rnmb_pkg::job_t                  slot_q [rnmb_pkg::QDEPTH];
  logic [rnmb_pkg::QPTR_W-1:0]     wr_ptr_q, rd_ptr_q;
  logic [rnmb_pkg::QCNT_W-1:0]     cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + rnmb_pkg::QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + rnmb_pkg::QPTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + rnmb_pkg::QCNT_W'(1);
      end else if (!push_i && pop_i) begin
        cnt_q <= cnt_q - rnmb_pkg::QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= job_i;
    end
  end

  assign job_o   = slot_q[rd_ptr_q];
  assign valid_o = cnt_q != '0;
  assign count_o = cnt_q;

  `RNMB_ASSERT(a_no_overflow, clk_i, rst_ni, !(push_i && (cnt_q == rnmb_pkg::QCNT_W'(rnmb_pkg::QDEPTH))), "push into full queue")
  `RNMB_ASSERT(a_no_underflow, clk_i, rst_ni, !(pop_i && (cnt_q == '0)), "pop from empty queue")
  `RNMB_ASSERT_NEXT(a_count_up, clk_i, rst_ni, push_i && !pop_i, cnt_q == ($past(cnt_q) + rnmb_pkg::QCNT_W'(1)), "queue count did not rise")

endmodule

// ----- sv/rnmb_back.sv -----
// ----------------------------------------------------------------------------
// rnmb_back
// Forms the neighbour mean or passes the border pixel, holds the result.
// ----------------------------------------------------------------------------
module rnmb_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  rnmb_pkg::job_t  job_i,
  input  logic            job_valid_i,
  output logic            pop_o,
  rnmb_res_if.source      out_o
);

  logic       out_valid_q;
  logic [7:0] red_q, green_q, blue_q;
  logic       end_q;
  logic [7:0] sum_r, sum_g, sum_b;

  assign pop_o = job_valid_i && (!out_valid_q || out_o.ready);

  always_comb begin
    sum_r = '0;
    sum_g = '0;
    sum_b = '0;
    for (int k = 0; k < 9; k++) begin
      if (k != 4) begin
        sum_r = sum_r + 8'(job_i.win[k].red[7:3]);
        sum_g = sum_g + 8'(job_i.win[k].green[7:3]);
        sum_b = sum_b + 8'(job_i.win[k].blue[7:3]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      red_q   <= job_i.interior ? sum_r : job_i.win[4].red;
      green_q <= job_i.interior ? sum_g : job_i.win[4].green;
      blue_q  <= job_i.interior ? sum_b : job_i.win[4].blue;
      end_q   <= job_i.last;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.red_out   = red_q;
  assign out_o.green_out = green_q;
  assign out_o.blue_out  = blue_q;
  assign out_o.frame_end = end_q;

endmodule

// ----- bench/rgb_neighbour_mean_blur_tb.sv -----
// ----------------------------------------------------------------------------
// rgb_neighbour_mean_blur_tb
// Self-checking bench for the 3x3 neighbour mean blur. A short table of
// directed beats walks reset sizes, a size change inside a frame, the tiny
// and zero sizes, a drain inside a frame and a saturated interior. A 12x12
// frame follows, during which the sink holds off long enough to fill the
// block, then random frames, some with the height changed while the frame
// is open. A beat-level line buffer and window model predicts every
// result, which is compared field by field. Both sides idle at random.
// ----------------------------------------------------------------------------
module rgb_neighbour_mean_blur_tb;

  localparam int CLK_PERIOD  = 4;
  localparam int LINE_MAX    = 2048;
  localparam int GAP_MAX     = 13;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE      = 8;
  localparam int TAIL        = 20;
  localparam int IDLE_LIMIT  = 2000;
  localparam int RAND_BEATS  = 500;

  typedef struct packed {
    rnmb_pkg::pixel_t px;
    logic             fend;
  } blur_exp_t;

  typedef enum bit {ROW_BEAT, ROW_WRITE} row_kind_e;

  typedef struct {
    row_kind_e                            kind;
    logic                                 op;
    rnmb_pkg::pixel_t                     px;
    logic [rnmb_pkg::CFG_IDX_W-1:0]       idx;
    logic [rnmb_pkg::CFG_DATA_W-1:0]      data;
    bit                                   known;
    rnmb_pkg::pixel_t                     exp_px;
    logic                                 exp_end;
  } stim_row_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  rnmb_pix_if pix_if ();
  rnmb_res_if res_if ();
  rnmb_cfg_if cfg_if ();

  rgb_neighbour_mean_blur #(
    .MAX_WIDTH(LINE_MAX)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (pix_if),
    .out_o (res_if),
    .cfg_i (cfg_if)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // blur model state
  logic [rnmb_pkg::FW_W-1:0] width_reg  = rnmb_pkg::FW_RESET;
  logic [rnmb_pkg::FH_W-1:0] height_reg = rnmb_pkg::FH_RESET;
  rnmb_pkg::pixel_t          upper_q  [LINE_MAX] = '{default: '0};
  rnmb_pkg::pixel_t          middle_q [LINE_MAX] = '{default: '0};
  rnmb_pkg::pixel_t          win      [9]        = '{default: '0};
  logic [10:0]               in_col  = '0;
  logic [1:0]                in_row  = '0;
  logic [10:0]               out_col = '0;
  logic [15:0]               out_row = '0;

  blur_exp_t   blur_expected[$];
  stim_row_t   dir_rows[$];
  int unsigned beats_sent   = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned idle_cycles  = 0;
  bit          src_burst    = 1'b0;
  bit          hold_armed   = 1'b0;

  function automatic int unsigned draw_gap(inout bit burst);
    if ($urandom_range(0, 39) == 0) burst = !burst;
    return burst ? 0 : $urandom_range(0, GAP_MAX);
  endfunction

  function automatic int unsigned eff_width();
    if (width_reg == '0) return 1;
    if (width_reg > LINE_MAX) return LINE_MAX;
    return 32'(width_reg);
  endfunction

  function automatic int unsigned eff_height();
    return (height_reg == '0) ? 1 : 32'(height_reg);
  endfunction

  function automatic bit frame_open();
    return (in_col != '0) || (in_row != '0) || (out_col != '0) || (out_row != '0);
  endfunction

  function automatic rnmb_pkg::pixel_t neighbour_mean();
    logic [7:0] r, g, b;
    r = '0;
    g = '0;
    b = '0;
    for (int k = 0; k < 9; k++) begin
      if (k != 4) begin
        r += win[k].red >> 3;
        g += win[k].green >> 3;
        b += win[k].blue >> 3;
      end
    end
    return {r, g, b};
  endfunction

  task automatic blur_step(input logic op, input rnmb_pkg::pixel_t px_in, output bit has,
                           output blur_exp_t res);
    int unsigned      ew, eh;
    rnmb_pkg::pixel_t px, up, mid;
    bit               full, interior, last;
    ew  = eff_width();
    eh  = eff_height();
    px  = (op == rnmb_pkg::OP_PIXEL) ? px_in : '0;
    up  = upper_q[in_col];
    mid = middle_q[in_col];
    upper_q[in_col]  = mid;
    middle_q[in_col] = px;
    for (int r = 0; r < 3; r++) begin
      win[r*3]   = win[r*3+1];
      win[r*3+1] = win[r*3+2];
    end
    win[2] = up;
    win[5] = mid;
    win[8] = px;
    full = (in_row >= 2) || (in_row == 1 && in_col >= 1);
    if (in_col + 1 >= ew) begin
      in_col = '0;
      if (in_row < 2) in_row++;
    end else begin
      in_col++;
    end
    has = full;
    res = '0;
    if (!full) return;
    interior = out_row >= 1 && out_row + 1 < eh && out_col >= 1 && out_col + 1 < ew;
    res.px   = interior ? neighbour_mean() : win[4];
    last     = (out_row + 1 >= eh) && (out_col + 1 >= ew);
    res.fend = last;
    if (last) begin
      in_col  = '0;
      in_row  = '0;
      out_col = '0;
      out_row = '0;
    end else if (out_col + 1 >= ew) begin
      out_col = '0;
      out_row++;
    end else begin
      out_col++;
    end
  endtask

  task automatic drive_beat(input logic op, input rnmb_pkg::pixel_t px, input bit known,
                            input rnmb_pkg::pixel_t exp_px, input logic exp_end);
    int unsigned gap;
    bit          has;
    blur_exp_t   res;
    gap = draw_gap(src_burst);
    if (gap != 0) begin
      pix_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pix_if.valid     <= 1'b1;
    pix_if.operation <= op;
    pix_if.red_in    <= px.red;
    pix_if.green_in  <= px.green;
    pix_if.blue_in   <= px.blue;
    @(posedge clk_i);
    while (!(pix_if.valid && pix_if.ready)) @(posedge clk_i);
    beats_sent++;
    blur_step(op, px, has, res);
    if (has) begin
      if (known) begin
        res.px   = exp_px;
        res.fend = exp_end;
      end
      blur_expected = {blur_expected, res};
    end
  endtask

  task automatic cfg_write(input logic [rnmb_pkg::CFG_IDX_W-1:0] idx,
                           input logic [rnmb_pkg::CFG_DATA_W-1:0] d);
    pix_if.valid <= 1'b0;
    while (blur_expected.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= d;
    @(posedge clk_i);
    while (!(cfg_if.valid && cfg_if.ready)) @(posedge clk_i);
    cfg_if.valid <= 1'b0;
    if (idx == rnmb_pkg::CFG_FRAME_WIDTH) width_reg = d[rnmb_pkg::FW_W-1:0];
    else height_reg = d[rnmb_pkg::FH_W-1:0];
  endtask

  // one frame of random content, optionally with the height moved while open
  task automatic send_frame(input logic [rnmb_pkg::CFG_DATA_W-1:0] wd,
                            input logic [rnmb_pkg::CFG_DATA_W-1:0] hd, input bit split);
    int unsigned npix, cut_a, cut_b;
    logic        op;
    cfg_write(rnmb_pkg::CFG_FRAME_WIDTH, wd);
    cfg_write(rnmb_pkg::CFG_FRAME_HEIGHT, hd);
    npix = eff_width() * eff_height();
    if (npix < 3) split = 1'b0;
    if (split) begin
      cut_a = $urandom_range(1, npix - 2);
      cut_b = $urandom_range(cut_a + 1, npix - 1);
    end
    for (int unsigned i = 0; i < npix; i++) begin
      if (split && i == cut_a) cfg_write(rnmb_pkg::CFG_FRAME_HEIGHT, 16'hFFFF);
      if (split && i == cut_b) begin
        cfg_write(rnmb_pkg::CFG_FRAME_HEIGHT, 16'($urandom_range(0, 8)));
      end
      op = ($urandom_range(0, 7) == 0) ? rnmb_pkg::OP_DRAIN : rnmb_pkg::OP_PIXEL;
      drive_beat(op, 24'($urandom), 1'b0, '0, 1'b0);
    end
    while (frame_open()) begin
      op = ($urandom_range(0, 3) == 0) ? rnmb_pkg::OP_PIXEL : rnmb_pkg::OP_DRAIN;
      drive_beat(op, 24'($urandom), 1'b0, '0, 1'b0);
    end
  endtask

  function automatic stim_row_t beat_row(logic op, rnmb_pkg::pixel_t px, bit known = 1'b0,
                                         rnmb_pkg::pixel_t exp_px = '0,
                                         logic exp_end = 1'b0);
    return '{ROW_BEAT, op, px, '0, '0, known, exp_px, exp_end};
  endfunction

  function automatic stim_row_t write_row(logic [rnmb_pkg::CFG_IDX_W-1:0] idx,
                                          logic [rnmb_pkg::CFG_DATA_W-1:0] d);
    return '{ROW_WRITE, rnmb_pkg::OP_PIXEL, '0, idx, d, 1'b0, '0, 1'b0};
  endfunction

  function automatic void add_row(stim_row_t row);
    dir_rows = {dir_rows, row};
  endfunction

  initial begin
    int unsigned rand_start, w, h;
    pix_if.valid     <= 1'b0;
    pix_if.operation <= rnmb_pkg::OP_PIXEL;
    pix_if.red_in    <= '0;
    pix_if.green_in  <= '0;
    pix_if.blue_in   <= '0;
    cfg_if.valid     <= 1'b0;
    cfg_if.index     <= '0;
    cfg_if.data      <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset sizes, then a smaller width while the line is open
    add_row(beat_row(rnmb_pkg::OP_PIXEL, 24'hFF00FF));
    add_row(beat_row(rnmb_pkg::OP_PIXEL, 24'h00FF00));
    add_row(beat_row(rnmb_pkg::OP_PIXEL, 24'hFFFFFF));
    add_row(write_row(rnmb_pkg::CFG_FRAME_WIDTH, 16'hF003));
    add_row(write_row(rnmb_pkg::CFG_FRAME_HEIGHT, 16'h0002));
    add_row(beat_row(rnmb_pkg::OP_PIXEL, 24'h000000));
    add_row(beat_row(rnmb_pkg::OP_PIXEL, 24'h0F0F0F));
    add_row(beat_row(rnmb_pkg::OP_PIXEL, 24'hF0F0F0));
    add_row(beat_row(rnmb_pkg::OP_PIXEL, 24'h5AA55A));
    for (int i = 0; i < 4; i++) add_row(beat_row(rnmb_pkg::OP_DRAIN, 24'h000000));
    // zero sizes count as one, pixel beat inside the drain
    add_row(write_row(rnmb_pkg::CFG_FRAME_WIDTH, 16'h0000));
    add_row(write_row(rnmb_pkg::CFG_FRAME_HEIGHT, 16'h0000));
    add_row(beat_row(rnmb_pkg::OP_PIXEL, 24'hFFFFFF));
    add_row(beat_row(rnmb_pkg::OP_DRAIN, 24'hFFFFFF));
    add_row(beat_row(rnmb_pkg::OP_PIXEL, 24'h00FF00, 1'b1, 24'hFFFFFF, 1'b1));
    // 3x3 white frame with a drain beat as its centre
    add_row(write_row(rnmb_pkg::CFG_FRAME_WIDTH, 16'h0003));
    add_row(write_row(rnmb_pkg::CFG_FRAME_HEIGHT, 16'h0003));
    for (int i = 0; i < 4; i++) add_row(beat_row(rnmb_pkg::OP_PIXEL, 24'hFFFFFF));
    add_row(beat_row(rnmb_pkg::OP_DRAIN, 24'hFFFFFF, 1'b1, 24'hFFFFFF));
    add_row(beat_row(rnmb_pkg::OP_PIXEL, 24'hFFFFFF, 1'b1, 24'hFFFFFF));
    add_row(beat_row(rnmb_pkg::OP_PIXEL, 24'hFFFFFF, 1'b1, 24'hFFFFFF));
    add_row(beat_row(rnmb_pkg::OP_PIXEL, 24'hFFFFFF, 1'b1, 24'hFFFFFF));
    add_row(beat_row(rnmb_pkg::OP_PIXEL, 24'hFFFFFF, 1'b1, 24'hF8F8F8));
    for (int i = 0; i < 3; i++) begin
      add_row(beat_row(rnmb_pkg::OP_DRAIN, 24'h000000, 1'b1, 24'hFFFFFF));
    end
    add_row(beat_row(rnmb_pkg::OP_DRAIN, 24'h000000, 1'b1, 24'hFFFFFF, 1'b1));

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_WRITE) begin
        cfg_write(dir_rows[i].idx, dir_rows[i].data);
      end else begin
        drive_beat(dir_rows[i].op, dir_rows[i].px, dir_rows[i].known,
                   dir_rows[i].exp_px, dir_rows[i].exp_end);
      end
    end

    // sink holds off during this frame
    hold_armed = 1'b1;
    send_frame(16'd12, 16'd12, 1'b0);

    rand_start = beats_sent;
    while (beats_sent - rand_start < RAND_BEATS) begin
      case ($urandom_range(0, 15)) inside
        0:       w = 0;
        [13:14]: w = $urandom_range(9, 40);
        default: w = $urandom_range(1, 8);
      endcase
      case ($urandom_range(0, 15))
        0:       h = 0;
        15:      h = $urandom_range(7, 12);
        default: h = $urandom_range(1, 6);
      endcase
      send_frame({4'($urandom), 12'(w)}, 16'(h), $urandom_range(0, 5) == 0);
    end
    pix_if.valid <= 1'b0;

    while (blur_expected.size() != 0) @(posedge clk_i);
    repeat (TAIL) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // result sink with random stalls and one long hold-off
  initial begin
    bit          sink_burst;
    bit          held;
    int unsigned gap;
    blur_exp_t   want;
    sink_burst = 1'b0;
    held       = 1'b0;
    res_if.ready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (!held && hold_armed) begin
        held = 1'b1;
        gap  = HOLD_CYCLES;
      end else begin
        gap = draw_gap(sink_burst);
      end
      if (gap != 0) begin
        res_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!(res_if.valid && res_if.ready)) @(posedge clk_i);
      if (blur_expected.size() == 0) begin
        $error("result beat with no expectation waiting");
        mismatch_cnt++;
      end else begin
        want = blur_expected.pop_front();
        if (res_if.red_out !== want.px.red) begin
          $error("red_out: expected %0d, got %0d", want.px.red, res_if.red_out);
          mismatch_cnt++;
        end
        if (res_if.green_out !== want.px.green) begin
          $error("green_out: expected %0d, got %0d", want.px.green, res_if.green_out);
          mismatch_cnt++;
        end
        if (res_if.blue_out !== want.px.blue) begin
          $error("blue_out: expected %0d, got %0d", want.px.blue, res_if.blue_out);
          mismatch_cnt++;
        end
        if (res_if.frame_end !== want.fend) begin
          $error("frame_end: expected %0d, got %0d", want.fend, res_if.frame_end);
          mismatch_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

endmodule

// ----- sim.f -----
+incdir+sv
sv/rnmb_pkg.sv
sv/rnmb_if.sv
sv/rnmb_ram.sv
sv/rnmb_front.sv
sv/rnmb_queue.sv
sv/rnmb_back.sv
sv/rgb_neighbour_mean_blur.sv
bench/rgb_neighbour_mean_blur_tb.sv
